FILE: src/decimal_string_to_uint64_saturating_macros.svh
// ----------------------------------------------------------------------------
// decimal string to uint64 parser: assertion macros
// concurrent assertion helpers, included by dsu_assert.sv alone among the source files
// ----------------------------------------------------------------------------
`ifndef DECIMAL_STRING_TO_UINT64_SATURATING_MACROS_SVH
`define DECIMAL_STRING_TO_UINT64_SATURATING_MACROS_SVH

// checked only while out of reset
`define DSU_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("dsu assertion failed");

// checked at every edge, reset included
`define DSU_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("dsu assertion failed");

`endif

FILE: src/dsu_pkg.sv
// ----------------------------------------------------------------------------
// dsu_pkg
// types, status codes and the power-of-ten table of the decimal parser
// ----------------------------------------------------------------------------
`default_nettype none

package dsu_pkg;

    localparam logic [7:0] CharZero = 8'd48;
    localparam logic [7:0] CharTwo  = 8'd50;
    localparam logic [7:0] CharNine = 8'd57;
    localparam logic [7:0] MaxLen   = 8'd20;
    localparam logic [7:0] PosMax   = 8'd255;

    typedef logic [1:0] t_status;

    localparam t_status STATUS_OK  = 2'd0;
    localparam t_status STATUS_SAT = 2'd1;
    localparam t_status STATUS_BAD = 2'd2;

    typedef struct packed {
        logic [7:0] character;
        logic [7:0] string_length;
        logic       is_last;
    } t_in_item;

    typedef struct packed {
        logic [63:0] value;
        t_status     status;
    } t_out_item;

    typedef struct packed {
        logic [63:0] total;
        logic [7:0]  pos;
        t_status     decided;
    } t_parse_state;

    function automatic logic [63:0] pow_ten(input logic [4:0] e);
        logic [63:0] w;
        case (e)
            5'd0:    w = 64'd1;
            5'd1:    w = 64'd10;
            5'd2:    w = 64'd100;
            5'd3:    w = 64'd1000;
            5'd4:    w = 64'd10000;
            5'd5:    w = 64'd100000;
            5'd6:    w = 64'd1000000;
            5'd7:    w = 64'd10000000;
            5'd8:    w = 64'd100000000;
            5'd9:    w = 64'd1000000000;
            5'd10:   w = 64'd10000000000;
            5'd11:   w = 64'd100000000000;
            5'd12:   w = 64'd1000000000000;
            5'd13:   w = 64'd10000000000000;
            5'd14:   w = 64'd100000000000000;
            5'd15:   w = 64'd1000000000000000;
            5'd16:   w = 64'd10000000000000000;
            5'd17:   w = 64'd100000000000000000;
            5'd18:   w = 64'd1000000000000000000;
            5'd19:   w = 64'd10000000000000000000;
            default: w = 64'd0;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

FILE: src/dsu_stream_if.sv
// ----------------------------------------------------------------------------
// dsu_stream_if
// valid/ready channel carrying one payload per transaction
// ----------------------------------------------------------------------------
`default_nettype none

interface dsu_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
    modport monitor (input valid, input payload, input ready);
endinterface

`default_nettype wire

FILE: src/dsu_digit_step.sv
// ----------------------------------------------------------------------------
// dsu_digit_step
// one character against the parse state: weight, add, overflow and outcome
// ----------------------------------------------------------------------------
`default_nettype none

module dsu_digit_step (
    input  dsu_pkg::t_in_item     i_item,
    input  dsu_pkg::t_parse_state i_state,
    output dsu_pkg::t_parse_state o_state_next,
    output dsu_pkg::t_out_item    o_result
);
    import dsu_pkg::*;

    logic [7:0]  ch;
    logic [7:0]  len;
    logic [7:0]  pos;
    logic        too_long;
    logic        counted;
    logic        is_digit;
    t_status     dec_first;
    t_status     dec_next;
    logic [7:0]  digit_full;
    logic [7:0]  exp_full;
    logic [63:0] weight;
    logic [67:0] product;
    logic [68:0] sum;
    logic [63:0] total_next;
    logic [7:0]  pos_next;

    always_comb begin
        ch  = i_item.character;
        len = i_item.string_length;
        pos = i_state.pos;

        too_long = (len > MaxLen) ||
                   ((len == MaxLen) && (ch >= CharTwo) && (ch <= CharNine));
        dec_first = ((pos == 8'd0) && (i_state.decided == STATUS_OK) && too_long)
                    ? STATUS_SAT : i_state.decided;

        counted  = (dec_first == STATUS_OK) && (pos < len) && (len <= MaxLen);
        is_digit = (ch >= CharZero) && (ch <= CharNine);

        digit_full = ch - CharZero;
        exp_full   = len - 8'd1 - pos;
        weight     = pow_ten(exp_full[4:0]);
        product    = 68'(weight) * 68'(digit_full[3:0]);
        sum        = 69'(i_state.total) + 69'(product);

        dec_next   = dec_first;
        total_next = i_state.total;
        if (counted) begin
            if (!is_digit) begin
                dec_next = STATUS_BAD;
            end else if ((product[67:64] != 4'd0) || (sum[68:64] != 5'd0)) begin
                dec_next = STATUS_SAT;
            end else begin
                total_next = sum[63:0];
            end
        end

        pos_next = (pos != PosMax) ? pos + 8'd1 : pos;

        case (dec_next)
            STATUS_SAT: begin
                o_result.value  = '1;
                o_result.status = STATUS_SAT;
            end
            STATUS_BAD: begin
                o_result.value  = '0;
                o_result.status = STATUS_BAD;
            end
            default: begin
                o_result.value  = total_next;
                o_result.status = STATUS_OK;
            end
        endcase

        if (i_item.is_last) begin
            o_state_next = '0;
        end else begin
            o_state_next.total   = total_next;
            o_state_next.pos     = pos_next;
            o_state_next.decided = dec_next;
        end
    end

endmodule

`default_nettype wire

FILE: src/decimal_string_to_uint64_saturating.sv
// ----------------------------------------------------------------------------
// decimal_string_to_uint64_saturating
// saturating ascii decimal to 64-bit unsigned parser; output stalls aside, one character a cycle
// ----------------------------------------------------------------------------
//  port     dir   payload                                   transaction
//  i_in     in    character, string_length, is_last          one character
//  o_out    out   value, status                              one parsed string
//
//  one character per cycle while the output is free for last characters; a
//  result passes the input register, then the digit step into the result reg
//  the digit step (4x64 multiply by a table power of ten, 69-bit add) sets
//  the clock path
//  synchronous active-low reset clears the parse state and both valids
//  a stalled output holds back only last characters; others keep flowing
// ----------------------------------------------------------------------------
`default_nettype none

module decimal_string_to_uint64_saturating (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    dsu_stream_if.sink      i_in,
    dsu_stream_if.source    o_out
);
    import dsu_pkg::*;

    logic         r_s1_valid;
    t_in_item     r_s1_item;
    t_parse_state r_state;
    logic         r_out_valid;
    t_out_item    r_out_item;

    t_parse_state n_state;
    t_out_item    n_out_item;
    logic         out_free;
    logic         s1_go;

    assign out_free   = !r_out_valid || o_out.ready;
    assign s1_go      = r_s1_valid && (!r_s1_item.is_last || out_free);
    assign i_in.ready = !r_s1_valid || s1_go;

    dsu_digit_step u_step (
        .i_item       (r_s1_item),
        .i_state      (r_state),
        .o_state_next (n_state),
        .o_result     (n_out_item)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_s1_valid <= i_in.valid;
            end
            if (s1_go) begin
                r_state <= n_state;
            end
            if (s1_go && r_s1_item.is_last) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_s1_item <= i_in.payload;
        end
        if (s1_go && r_s1_item.is_last) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out_item;

endmodule

`default_nettype wire

FILE: src/dsu_assert.sv
// ----------------------------------------------------------------------------
// dsu_assert
// port-level checks of the decimal parser, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "decimal_string_to_uint64_saturating_macros.svh"

module dsu_assert (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_out_valid,
    input  wire logic             i_out_ready,
    input  wire logic [63:0]      i_out_value,
    input  wire dsu_pkg::t_status i_out_status
);
    import dsu_pkg::*;

    logic out_wait;
    logic out_sat;
    logic out_bad;

    assign out_wait = i_out_valid && !i_out_ready;
    assign out_sat  = i_out_valid && (i_out_status == STATUS_SAT);
    assign out_bad  = i_out_valid && (i_out_status == STATUS_BAD);

    `DSU_ASSERT(a_out_hold, i_clk, i_rst_n, out_wait |=> i_out_valid)
    `DSU_ASSERT(a_out_stable, i_clk, i_rst_n, out_wait |=> $stable({i_out_value, i_out_status}))
    `DSU_ASSERT(a_sat_max, i_clk, i_rst_n, out_sat |-> (i_out_value == '1))
    `DSU_ASSERT(a_bad_zero, i_clk, i_rst_n, out_bad |-> (i_out_value == '0))
    `DSU_ASSERT_ALWAYS(a_rst_idle, i_clk, !i_rst_n |=> !i_out_valid)

endmodule

bind decimal_string_to_uint64_saturating dsu_assert u_dsu_assert (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_value  (o_out.payload.value),
    .i_out_status (o_out.payload.status)
);

`default_nettype wire

FILE: test/tb_decimal_string_to_uint64_saturating.sv
// ----------------------------------------------------------------------------
// tb_decimal_string_to_uint64_saturating
// self-checking testbench for the saturating decimal string parser
//
// a queue of characters is filled up front: a short directed set (empty
// strings, single digits, too-long lengths, overflow, non-digit bytes,
// extra and missing characters, length changes within a string), then
// random strings, many well formed and some close to the 64-bit limit, mixed
// with noise. a clocked driver feeds the input channel with random idle
// bursts, and the sink stalls in bursts. every accepted character runs
// through a local model of the parser; each parsed result is compared
// field by field with the oldest predicted one.
// ----------------------------------------------------------------------------
module tb_decimal_string_to_uint64_saturating;
    timeunit 1ns;
    timeprecision 1ps;

    import dsu_pkg::*;

    localparam int TailItems = 150;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    dsu_stream_if #(.t_payload(t_in_item))  in_if ();
    dsu_stream_if #(.t_payload(t_out_item)) out_if ();

    decimal_string_to_uint64_saturating DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if.sink),
        .o_out   (out_if.source)
    );

    t_in_item    char_q[$];
    t_out_item   parsed_q[$];
    logic [63:0] weight [20];

    logic [63:0] acc_total;
    logic [7:0]  acc_pos;
    t_status     acc_decided;

    int errors = 0;
    int src_gap = 0;
    int snk_gap = 0;
    int src_idle_pct = 10;
    int snk_idle_pct = 10;
    int sent_cnt = 0;
    int result_cnt = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // local model of one parser step
    task automatic parse_char(input t_in_item it);
        logic [63:0] d;
        logic [7:0]  e;
        logic [67:0] prod;
        logic [64:0] sum;
        t_out_item   res;
        if (acc_pos == 8'd0 && acc_decided == STATUS_OK) begin
            if (it.string_length > MaxLen ||
                (it.string_length == MaxLen && it.character >= CharTwo &&
                 it.character <= CharNine))
                acc_decided = STATUS_SAT;
        end
        if (acc_decided == STATUS_OK && acc_pos < it.string_length &&
            it.string_length <= MaxLen) begin
            if (it.character < CharZero || it.character > CharNine) begin
                acc_decided = STATUS_BAD;
            end else begin
                d = 64'(it.character - CharZero);
                e = it.string_length - 8'd1 - acc_pos;
                prod = d * weight[e];
                if (prod[67:64] != 4'd0) begin
                    acc_decided = STATUS_SAT;
                end else begin
                    sum = {1'b0, acc_total} + {1'b0, prod[63:0]};
                    if (sum[64])
                        acc_decided = STATUS_SAT;
                    else
                        acc_total = sum[63:0];
                end
            end
        end
        if (acc_pos != PosMax)
            acc_pos = acc_pos + 8'd1;
        if (it.is_last) begin
            res.status = acc_decided;
            if (acc_decided == STATUS_SAT)
                res.value = '1;
            else if (acc_decided == STATUS_BAD)
                res.value = '0;
            else
                res.value = acc_total;
            parsed_q.push_back(res);
            acc_total = '0;
            acc_pos = '0;
            acc_decided = STATUS_OK;
        end
    endtask

    task automatic push_char(input logic [7:0] c, input logic [7:0] len, input logic last);
        t_in_item it;
        it.character = c;
        it.string_length = len;
        it.is_last = last;
        char_q.push_back(it);
    endtask

    task automatic push_digits(input string s);
        for (int i = 0; i < s.len(); i++)
            push_char(s[i], 8'(s.len()), i == s.len() - 1);
    endtask

    function automatic logic [7:0] rand_digit();
        return CharZero + 8'($urandom_range(9));
    endfunction

    function automatic logic [7:0] rand_nondigit();
        logic [7:0] c;
        c = 8'($urandom_range(255));
        while (c >= CharZero && c <= CharNine)
            c = 8'($urandom_range(255));
        return c;
    endfunction

    task automatic push_random_string();
        string       max_str;
        int          kind;
        int          n;
        int          len;
        int          k;
        int          bad_at;
        logic [7:0]  c;
        max_str = "18446744073709551615";
        kind = $urandom_range(99);
        if (kind < 45) begin
            // well formed, often 20 digits around the 64-bit limit
            len = ($urandom_range(9) < 6) ? $urandom_range(1, 19) : 20;
            k = $urandom_range(20);
            for (int i = 0; i < len; i++) begin
                if (len == 20 && i < k)
                    c = max_str[i];
                else
                    c = rand_digit();
                push_char(c, 8'(len), i == len - 1);
            end
        end else if (kind < 53) begin
            push_char(8'($urandom_range(255)), 8'd0, 1'b1);
        end else if (kind < 63) begin
            len = $urandom_range(1, 20);
            bad_at = $urandom_range(len - 1);
            for (int i = 0; i < len; i++) begin
                c = (i == bad_at) ? rand_nondigit() : rand_digit();
                if (len == 20 && i == 0 && i != bad_at)
                    c = CharZero + 8'($urandom_range(1));
                push_char(c, 8'(len), i == len - 1);
            end
        end else if (kind < 70) begin
            len = $urandom_range(21, 255);
            n = $urandom_range(1, 4);
            for (int i = 0; i < n; i++)
                push_char(($urandom_range(3) == 0) ? rand_nondigit() : rand_digit(),
                          8'(len), i == n - 1);
        end else if (kind < 80) begin
            len = $urandom_range(1, 20);
            n = $urandom_range(1, len + 4);
            for (int i = 0; i < n; i++) begin
                c = ($urandom_range(15) == 0) ? 8'($urandom_range(255)) : rand_digit();
                if (len == 20 && i == 0)
                    c = CharZero + 8'($urandom_range(1));
                push_char(c, 8'(len), i == n - 1);
            end
        end else begin
            // noise, length changing per character
            n = $urandom_range(1, 8);
            for (int i = 0; i < n; i++) begin
                len = ($urandom_range(1) == 0) ? $urandom_range(255) : $urandom_range(22);
                c = ($urandom_range(1) == 0) ? 8'($urandom_range(255)) : rand_digit();
                push_char(c, 8'(len), i == n - 1);
            end
        end
    endtask

    // input driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else if (!in_if.valid || in_if.ready) begin
            if (src_gap > 0) begin
                src_gap = src_gap - 1;
                in_if.valid <= 1'b0;
            end else if (char_q.size() > TailItems && $urandom_range(99) < src_idle_pct) begin
                src_gap = $urandom_range(1, 18) - 1;
                in_if.valid <= 1'b0;
            end else if (char_q.size() > 0) begin
                in_if.valid <= 1'b1;
                in_if.payload <= char_q.pop_front();
                sent_cnt = sent_cnt + 1;
                if (sent_cnt % 200 == 0) begin
                    case ($urandom_range(3))
                        0: src_idle_pct = 0;
                        1: src_idle_pct = 4;
                        2: src_idle_pct = 12;
                        default: src_idle_pct = 30;
                    endcase
                end
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // output sink with stall bursts
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else if (snk_gap > 0) begin
            snk_gap = snk_gap - 1;
            out_if.ready <= 1'b0;
        end else if (char_q.size() > TailItems && $urandom_range(99) < snk_idle_pct) begin
            snk_gap = $urandom_range(1, 18) - 1;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= 1'b1;
        end
    end

    // monitor: predict on accepted characters, check accepted results
    always @(posedge i_clk) begin : monitor
        t_out_item want;
        if (i_rst_n) begin
            if (in_if.valid && in_if.ready)
                parse_char(in_if.payload);
            if (out_if.valid && out_if.ready) begin
                result_cnt = result_cnt + 1;
                if (result_cnt % 60 == 0) begin
                    case ($urandom_range(3))
                        0: snk_idle_pct = 0;
                        1: snk_idle_pct = 5;
                        2: snk_idle_pct = 15;
                        default: snk_idle_pct = 40;
                    endcase
                end
                if (parsed_q.size() == 0) begin
                    $display("%0t: unexpected result value=%h status=%0d", $realtime,
                             out_if.payload.value, out_if.payload.status);
                    errors = errors + 1;
                end else begin
                    want = parsed_q.pop_front();
                    if (out_if.payload.value !== want.value) begin
                        $display("%0t: value mismatch expected=%h actual=%h", $realtime,
                                 want.value, out_if.payload.value);
                        errors = errors + 1;
                    end
                    if (out_if.payload.status !== want.status) begin
                        $display("%0t: status mismatch expected=%0d actual=%0d", $realtime,
                                 want.status, out_if.payload.status);
                        errors = errors + 1;
                    end
                end
            end
        end
    end

    initial begin
        in_if.valid = 1'b0;
        in_if.payload = '0;
        out_if.ready = 1'b0;
        acc_total = '0;
        acc_pos = '0;
        acc_decided = STATUS_OK;
        weight[0] = 64'd1;
        for (int i = 1; i < 20; i++)
            weight[i] = weight[i - 1] * 64'd10;

        // empty string and single digits
        push_char(8'($urandom_range(255)), 8'd0, 1'b1);
        push_digits("0");
        push_digits("9");
        // too long
        push_char("1", 8'd21, 1'b1);
        push_char("0", 8'd255, 1'b1);
        push_char("2", 8'd20, 1'b1);
        push_char("9", 8'd20, 1'b1);
        // short string with twenty declared digits
        push_char("1", 8'd20, 1'b1);
        // addition overflow
        push_char("1", 8'd20, 1'b0);
        push_char("9", 8'd20, 1'b1);
        // non-digit bytes
        push_char(8'hff, 8'd1, 1'b1);
        push_char(8'h00, 8'd1, 1'b1);
        push_char("/", 8'd1, 1'b1);
        push_char(":", 8'd1, 1'b1);
        push_char(8'h80, 8'd1, 1'b1);
        // characters past the declared length
        push_char("5", 8'd1, 1'b0);
        push_char("7", 8'd1, 1'b0);
        push_char("x", 8'd1, 1'b1);
        // outcome already decided
        push_char("a", 8'd2, 1'b0);
        push_char("9", 8'd2, 1'b1);
        // zero length over two characters
        push_char("5", 8'd0, 1'b0);
        push_char("5", 8'd0, 1'b1);
        // length changing within a string
        push_char("3", 8'd3, 1'b0);
        push_char("4", 8'd1, 1'b1);

        while (char_q.size() < 1320)
            push_random_string();

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (char_q.size() > 0 || in_if.valid || parsed_q.size() > 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (errors == 0) begin
            $display("PASS decimal_string_to_uint64_saturating");
        end else begin
            $display("FAIL decimal_string_to_uint64_saturating");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("FAIL decimal_string_to_uint64_saturating");
        $finish;
    end

endmodule
